// ===== rtl/cursor_array_list_engine_unit_macros.svh =====
// Assertion macros for the cursor list engine.
`ifndef CURSOR_ARRAY_LIST_ENGINE_UNIT_MACROS_SVH
`define CURSOR_ARRAY_LIST_ENGINE_UNIT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define CALE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define CALE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/cale_pkg.sv =====
// Shared codes, field widths and control structs for the cursor list engine.
`default_nettype none

package cale_pkg;

  localparam int MODE_W = 4;
  localparam int VAL_W  = 32;
  localparam int POS_W  = 5;
  localparam int STAT_W = 2;
  localparam int LEN_W  = 5;
  localparam int CPOS_W = 4;

  localparam logic [MODE_W-1:0] MODE_INSERT = 4'd0;
  localparam logic [MODE_W-1:0] MODE_APPEND = 4'd1;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 4'd2;
  localparam logic [MODE_W-1:0] MODE_START  = 4'd3;
  localparam logic [MODE_W-1:0] MODE_END    = 4'd4;
  localparam logic [MODE_W-1:0] MODE_PREV   = 4'd5;
  localparam logic [MODE_W-1:0] MODE_NEXT   = 4'd6;
  localparam logic [MODE_W-1:0] MODE_GOTO   = 4'd7;
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 4'd8;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd3;

  // controller -> datapath
  typedef struct packed {
    logic cap;     // latch request item
    logic init;    // load walk pointer
    logic shift;   // one step of the entry walk
    logic drain;   // last lagging write of the walk
    logic put;     // write new value
    logic commit;  // update length, cursor, status
    logic fetch;   // read entry under new cursor
    logic strobe;  // present result
  } cale_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic do_shift;
    logic do_put;
    logic ptr_end;
  } cale_stat_t;

endpackage

`default_nettype wire

// ===== rtl/cale_dpath.sv =====
// Datapath: entry memory, length and cursor registers, walk pointer, result fields.
`default_nettype none

module cale_dpath #(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire cale_pkg::cale_cmd_t        cmd,
  output cale_pkg::cale_stat_t            stat,
  input  wire logic [cale_pkg::MODE_W-1:0] in_mode,
  input  wire logic [cale_pkg::VAL_W-1:0]  in_item_value,
  input  wire logic [cale_pkg::POS_W-1:0]  in_target_position,
  output logic [cale_pkg::STAT_W-1:0]      out_status,
  output logic [cale_pkg::VAL_W-1:0]       out_removed_value,
  output logic [cale_pkg::VAL_W-1:0]       out_cursor_value,
  output logic [cale_pkg::LEN_W-1:0]       out_list_length,
  output logic [cale_pkg::CPOS_W-1:0]      out_cursor_position
);
  import cale_pkg::*;

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > POS_W) ? CW : POS_W;

  logic [DATA_WIDTH-1:0] mem [CAPACITY];
  logic [DATA_WIDTH-1:0] rd_data_r;
  logic [IW-1:0]         rd_addr;
  logic                  we;
  logic [IW-1:0]         wa;
  logic [DATA_WIDTH-1:0] wd;

  logic [MODE_W-1:0]     mode_r;
  logic [DATA_WIDTH-1:0] val_r;
  logic [POS_W-1:0]      pos_r;
  logic [CW-1:0]         count_r, count_nxt;
  logic [IW-1:0]         cur_r, cur_nxt;
  logic [STAT_W-1:0]     status_r, status_nxt;
  logic [DATA_WIDTH-1:0] removed_r;
  logic [IW-1:0]         ptr_r;
  logic [IW-1:0]         prev_r;
  logic                  lag_r;
  logic                  first_r;

  logic          is_ins, is_app, is_rem, full, empty;
  logic [CW-1:0] last_cnt;
  logic [IW-1:0] last_idx;
  logic [PW-1:0] pos_w;

  assign is_ins   = (mode_r == MODE_INSERT);
  assign is_app   = (mode_r == MODE_APPEND);
  assign is_rem   = (mode_r == MODE_REMOVE);
  assign full     = (count_r == CW'(CAPACITY));
  assign empty    = (count_r == '0);
  assign last_cnt = count_r - CW'(1);
  assign last_idx = IW'(last_cnt);
  assign pos_w    = PW'(pos_r);

  assign stat.do_shift = (is_ins && !full && !empty) || (is_rem && !empty);
  assign stat.do_put   = (is_ins || is_app) && !full;
  assign stat.ptr_end  = is_rem ? (ptr_r == last_idx) : (ptr_r == cur_r);

  // the walk reads at the pointer; otherwise the cursor entry is read
  assign rd_addr = cmd.shift ? ptr_r : cur_r;

  // first read of a removal is the removed entry, not a move
  always_comb begin
    we = 1'b0;
    wa = is_rem ? (prev_r - IW'(1)) : (prev_r + IW'(1));
    wd = rd_data_r;
    if (cmd.put) begin
      we = 1'b1;
      wa = is_app ? IW'(count_r) : cur_r;
      wd = val_r;
    end else if ((cmd.shift || cmd.drain) && lag_r && !(is_rem && first_r)) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_comb begin
    count_nxt  = count_r;
    cur_nxt    = cur_r;
    status_nxt = ST_OK;
    case (mode_r)
      MODE_INSERT: begin
        if (full) status_nxt = ST_FULL;
        else count_nxt = count_r + CW'(1);
      end
      MODE_APPEND: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          count_nxt = count_r + CW'(1);
          cur_nxt   = IW'(count_r);
        end
      end
      MODE_REMOVE: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          count_nxt = last_cnt;
          if ((cur_r == last_idx) && (cur_r != '0)) cur_nxt = cur_r - IW'(1);
        end
      end
      MODE_START: cur_nxt = '0;
      MODE_END:   cur_nxt = empty ? '0 : last_idx;
      MODE_PREV: begin
        if (cur_r != '0) cur_nxt = cur_r - IW'(1);
      end
      MODE_NEXT: begin
        if (!empty && (CW'(cur_r) < last_cnt)) cur_nxt = cur_r + IW'(1);
      end
      MODE_GOTO: begin
        if ((pos_w != '0) && (pos_w <= PW'(count_r))) cur_nxt = IW'(pos_w - PW'(1));
        else status_nxt = ST_RANGE;
      end
      MODE_CLEAR: begin
        count_nxt = '0;
        cur_nxt   = '0;
      end
      default: begin
        count_nxt = count_r;
      end
    endcase
  end

  // request payload and walk data
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      mode_r    <= in_mode;
      val_r     <= DATA_WIDTH'(in_item_value);
      pos_r     <= in_target_position;
      removed_r <= '0;
    end
    if (cmd.init) begin
      ptr_r <= is_rem ? cur_r : last_idx;
    end
    if (cmd.shift) begin
      prev_r <= ptr_r;
      ptr_r  <= is_rem ? (ptr_r + IW'(1)) : (ptr_r - IW'(1));
    end
    if ((cmd.shift || cmd.drain) && lag_r && first_r && is_rem) begin
      removed_r <= rd_data_r;
    end
    if (cmd.commit) begin
      status_r <= status_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      cur_r   <= '0;
      lag_r   <= 1'b0;
      first_r <= 1'b0;
    end else begin
      if (cmd.init) begin
        lag_r   <= 1'b0;
        first_r <= 1'b1;
      end else begin
        if (cmd.shift) lag_r <= 1'b1;
        if ((cmd.shift || cmd.drain) && lag_r) first_r <= 1'b0;
      end
      if (cmd.commit) begin
        count_r <= count_nxt;
        cur_r   <= cur_nxt;
      end
    end
  end

  assign out_status          = status_r;
  assign out_removed_value   = VAL_W'(removed_r);
  assign out_cursor_value    = empty ? '0 : VAL_W'(rd_data_r);
  assign out_list_length     = LEN_W'(count_r);
  assign out_cursor_position = CPOS_W'(cur_r);

endmodule

`default_nettype wire

// ===== rtl/cale_ctrl.sv =====
// Controller: sequences capture, entry walk, write, commit, cursor read and result strobe.
`default_nettype none

module cale_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire cale_pkg::cale_stat_t stat,
  output cale_pkg::cale_cmd_t       cmd
);
  import cale_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_SHIFT  = 3'd2;
  localparam logic [2:0] S_DRAIN  = 3'd3;
  localparam logic [2:0] S_PUT    = 3'd4;
  localparam logic [2:0] S_COMMIT = 3'd5;
  localparam logic [2:0] S_FETCH  = 3'd6;
  localparam logic [2:0] S_OUT    = 3'd7;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.cap   = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.init = 1'b1;
        if (stat.do_shift)    state_nxt = S_SHIFT;
        else if (stat.do_put) state_nxt = S_PUT;
        else                  state_nxt = S_COMMIT;
      end
      S_SHIFT: begin
        cmd.shift = 1'b1;
        if (stat.ptr_end) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        cmd.drain = 1'b1;
        state_nxt = stat.do_put ? S_PUT : S_COMMIT;
      end
      S_PUT: begin
        cmd.put   = 1'b1;
        state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = S_FETCH;
      end
      S_FETCH: begin
        cmd.fetch = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        cmd.strobe = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

`default_nettype wire

// ===== rtl/cursor_array_list_engine_unit.sv =====
// Cursor list engine: a bounded ordered list with a cursor, one operation per item.
//
// One item at a time: start is taken while busy is low, and the result shows on the out_
// ports for one cycle with out_valid high; it must be taken then, as nothing holds it.
// Cursor moves, goto, clear and refused requests pass through exec, commit, fetch and the
// result strobe; append, and insert into an empty list, also pass through put. Insert
// into a non-empty list first walks the entries from the tail down to the cursor, and
// remove walks them from the cursor up to the tail, moving one entry per cycle through the
// entry memory, which has one read and one write port; a drain step ends each walk. busy
// drops the cycle after the strobe. The worst cases are an insert at the head of a
// 15-entry list and a remove at the head of a full list, which take equally long.
`default_nettype none

module cursor_array_list_engine_unit #(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [cale_pkg::MODE_W-1:0] in_mode,
  input  wire logic [cale_pkg::VAL_W-1:0]  in_item_value,
  input  wire logic [cale_pkg::POS_W-1:0]  in_target_position,
  output logic                             out_valid,
  output logic [cale_pkg::STAT_W-1:0]      out_status,
  output logic [cale_pkg::VAL_W-1:0]       out_removed_value,
  output logic [cale_pkg::VAL_W-1:0]       out_cursor_value,
  output logic [cale_pkg::LEN_W-1:0]       out_list_length,
  output logic [cale_pkg::CPOS_W-1:0]      out_cursor_position
);
  import cale_pkg::*;

  // bound checks only hold while the list fits the reported field widths
  localparam bit FITS = (CAPACITY <= 16);

  cale_cmd_t  cmd;
  cale_stat_t stat;
  logic       res_chk;
  logic       res_some;
  logic       res_none;

  cale_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  cale_dpath #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dpath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .stat                (stat),
    .in_mode             (in_mode),
    .in_item_value       (in_item_value),
    .in_target_position  (in_target_position),
    .out_status          (out_status),
    .out_removed_value   (out_removed_value),
    .out_cursor_value    (out_cursor_value),
    .out_list_length     (out_list_length),
    .out_cursor_position (out_cursor_position)
  );

  assign out_valid = cmd.strobe;

  assign res_chk  = out_valid && FITS;
  assign res_some = res_chk && (out_list_length != '0);
  assign res_none = res_chk && (out_list_length == '0);

`include "cursor_array_list_engine_unit_macros.svh"

  `CALE_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")
  `CALE_ASSERT_NEXT(a_one_strobe, out_valid, !out_valid && !busy, "result strobe not single")
  `CALE_ASSERT_NOW(a_len_bound, res_chk, out_list_length <= CAPACITY, "length too big")
  `CALE_ASSERT_NOW(a_cur_bound, res_some, out_cursor_position < out_list_length, "cursor off list")
  `CALE_ASSERT_NOW(a_empty_val, res_none, ~|{out_cursor_value, out_cursor_position}, "entry on empty")

endmodule

`default_nettype wire
